### rtl/sts_pkg.sv
// shared types, display codes and segment table for the signed tenths display scanner
package sts_pkg;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned CodeWidth = 4;
  localparam int unsigned ValueWidth = 15;
  localparam int unsigned MagWidth = 14;
  localparam int unsigned SegWidth = 8;
  localparam int unsigned PosWidth = 2;

  typedef logic [CodeWidth-1:0] code_t;
  typedef code_t [NumDigits-1:0] codes_t;
  typedef logic [SegWidth-1:0] seg_t;
  typedef logic [PosWidth-1:0] pos_t;
  typedef logic [NumDigits-1:0] enable_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  localparam code_t CODE_BLANK = 4'd10;
  localparam code_t CODE_MINUS = 4'd11;

  localparam pos_t POINT_POS = 2'd2;
  localparam int unsigned PointBit = 7;

  typedef struct packed {
    logic   update;
    codes_t codes;
  } split_t;

  // active-low pattern, bit 7 is the decimal point
  function automatic seg_t seg_pattern(code_t code);
    seg_t seg;
    case (code)
      4'd0:       seg = 8'b1100_0000;
      4'd1:       seg = 8'b1111_1001;
      4'd2:       seg = 8'b1010_0100;
      4'd3:       seg = 8'b1011_0000;
      4'd4:       seg = 8'b1001_1001;
      4'd5:       seg = 8'b1001_0010;
      4'd6:       seg = 8'b1000_0010;
      4'd7:       seg = 8'b1111_1000;
      4'd8:       seg = 8'b1000_0000;
      4'd9:       seg = 8'b1001_0000;
      CODE_MINUS: seg = 8'b1011_1111;
      default:    seg = 8'b1111_1111;
    endcase
    return seg;
  endfunction

endpackage

### rtl/sts_in_if.sv
// input channel: command and value beats
interface sts_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       command;
  logic signed [sts_pkg::ValueWidth-1:0]      value;

  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

### rtl/sts_out_if.sv
// output channel: segment pattern and digit enable beats
interface sts_out_if;
  logic                            valid;
  logic                            ready;
  logic [sts_pkg::SegWidth-1:0]    segments;
  logic [sts_pkg::NumDigits-1:0]   digit_enable;

  modport source (output valid, segments, digit_enable, input ready);
  modport sink (input valid, segments, digit_enable, output ready);
endinterface

### rtl/sts_digit_split.sv
// splits a signed tenths value into four display codes with blanks and minus sign
module sts_digit_split (
  input  logic signed [sts_pkg::ValueWidth-1:0] value,
  output sts_pkg::split_t                       split
);

  logic                              neg;
  logic [sts_pkg::ValueWidth-1:0]    abs_full;
  logic [sts_pkg::MagWidth-1:0]      mag;
  logic [26:0]                       p10;
  logic [26:0]                       p100;
  logic [26:0]                       p1000;
  logic [9:0]                        q10;
  logic [6:0]                        q100;
  logic [3:0]                        q1000;
  logic [13:0]                       ones_w;
  logic [9:0]                        tens_w;
  logic [6:0]                        hund_w;
  sts_pkg::code_t                    ones;
  sts_pkg::code_t                    tens;
  sts_pkg::code_t                    hund;

  assign neg      = value[sts_pkg::ValueWidth-1];
  assign abs_full = neg ? (~value + 15'd1) : value;
  assign mag      = abs_full[sts_pkg::MagWidth-1:0];

  // reciprocal multiplies, exact for magnitudes up to 9999
  assign p10   = {13'd0, mag} * 27'd6554;
  assign p100  = {13'd0, mag} * 27'd5243;
  assign p1000 = {13'd0, mag} * 27'd8389;
  assign q10   = p10[25:16];
  assign q100  = p100[25:19];
  assign q1000 = p1000[26:23];

  assign ones_w = mag - ({4'd0, q10} * 14'd10);
  assign tens_w = q10 - ({3'd0, q100} * 10'd10);
  assign hund_w = q100 - ({3'd0, q1000} * 7'd10);
  assign ones   = ones_w[3:0];
  assign tens   = tens_w[3:0];
  assign hund   = hund_w[3:0];

  always_comb begin
    split.codes[3] = ones;
    split.codes[2] = tens;
    split.codes[1] = hund;
    split.codes[0] = q1000;
    if (neg) begin
      split.update = (value >= -15'sd999);
      if (mag < 14'd100) begin
        split.codes[0] = sts_pkg::CODE_BLANK;
        split.codes[1] = sts_pkg::CODE_MINUS;
      end else begin
        split.codes[0] = sts_pkg::CODE_MINUS;
      end
    end else begin
      split.update = (value <= 15'sd9999);
      if (mag < 14'd100) begin
        split.codes[0] = sts_pkg::CODE_BLANK;
        split.codes[1] = sts_pkg::CODE_BLANK;
      end else if (mag < 14'd1000) begin
        split.codes[0] = sts_pkg::CODE_BLANK;
      end
    end
  end

endmodule

### rtl/signed_tenths_seven_segment_scan.sv
// top level: four-digit multiplexed seven-segment scanner for a signed value in tenths
//
// items: each beat carries command and value. a load beat (command 0) splits value
// into four display codes; values below -999 or above 9999 are ignored. a load
// gives no result beat.
// results: a tick beat (command 1) gives one beat with the active-low segment
// pattern of the current position (decimal point on position 2) and a one-hot
// digit enable, then the position steps 0,1,2,3,0...
// path: an accepted beat is held in the input register, and a tick result is then
// loaded into the output register, where it waits until the receiver takes it.
// throughput: one beat per cycle while results are taken; the digit split is a
// set of constant reciprocal multiplies and the segment table a small lookup,
// both combinational.
// reset: all four digits show zero, position returns to 0, both registers empty.
// stall: when the receiver holds ready low, the result waits in the output
// register; one further tick beat is held in the input register and items
// ready then drops. loads in the input register still complete while results stall.
module signed_tenths_seven_segment_scan (
  input  logic       clk,
  input  logic       rst,
  sts_in_if.sink     items,
  sts_out_if.source  results
);

  logic                                   in_valid;
  logic                                   in_command;
  logic signed [sts_pkg::ValueWidth-1:0]  in_value;
  logic                                   in_advance;
  logic                                   in_is_tick;

  sts_pkg::codes_t                        digit_codes;
  sts_pkg::pos_t                          scan_position;
  sts_pkg::split_t                        split;

  logic                                   out_valid;
  sts_pkg::seg_t                          segments;
  sts_pkg::enable_t                       digit_enable;
  sts_pkg::seg_t                          seg_next;
  sts_pkg::enable_t                       enable_next;

  sts_digit_split u_split (
    .value (in_value),
    .split (split)
  );

  assign in_is_tick    = (in_command == sts_pkg::CMD_TICK);
  assign in_advance    = in_valid && (!in_is_tick || !out_valid || results.ready);
  assign items.ready   = !in_valid || in_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
    if (items.ready && items.valid) begin
      in_command <= items.command;
      in_value   <= items.value;
    end
  end

  // digit store and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_codes   <= '0;
      scan_position <= '0;
    end else if (in_advance) begin
      if (in_is_tick) begin
        scan_position <= scan_position + 2'd1;
      end else if (split.update) begin
        digit_codes <= split.codes;
      end
    end
  end

  always_comb begin
    seg_next    = sts_pkg::seg_pattern(digit_codes[scan_position]);
    if (scan_position == sts_pkg::POINT_POS) begin
      seg_next[sts_pkg::PointBit] = 1'b0;
    end
    enable_next = sts_pkg::enable_t'(1) << scan_position;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance && in_is_tick) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (in_advance && in_is_tick) begin
      segments     <= seg_next;
      digit_enable <= enable_next;
    end
  end

  assign results.valid        = out_valid;
  assign results.segments     = segments;
  assign results.digit_enable = digit_enable;

endmodule
